/* hw/rtl/pd_pkg.sv */
// Package for the presence debouncer: field widths, codes, config and control types.
// Used by pd_ctrl, pd_dp, presence_debouncer and pd_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pd_pkg;

    // Hit window sizing
    localparam int MAX_HITS     = 8;
    localparam int LEAST_GAP_MS = 1000;
    localparam int HIT_CNT_W    = $clog2(MAX_HITS + 1);
    localparam int HIT_IDX_W    = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;

    // Field widths
    localparam int OP_W     = 2;
    localparam int TIME_W   = 64;
    localparam int RSSI_W   = 8;
    localparam int PRES_W   = 2;
    localparam int SMOOTH_W = 16;
    localparam int CNT_W    = 32;
    localparam int HITS_W   = 4;

    // Config register widths
    localparam int SIGHT_W = 4;
    localparam int WIN_W   = 20;
    localparam int ABS_W   = 22;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Smoothing arithmetic: s += (diff * 0.3 in Q16 + half) >> 16
    localparam int DIFF_W = SMOOTH_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = SMOOTH_W + 3;
    localparam logic signed [DIFF_W-1:0] SMOOTH_K  = 17'sd19661;
    localparam logic signed [PROD_W-1:0] ROUND_K   = 34'sd32768;
    localparam logic signed [SUM_W-1:0]  SMOOTH_HI = 19'sd32767;
    localparam logic signed [SUM_W-1:0]  SMOOTH_LO = -19'sd32768;

    typedef enum logic [OP_W-1:0] {
        OP_COVERAGE = 2'd0,
        OP_SIGHTING = 2'd1,
        OP_TICK     = 2'd2
    } opcode_t;

    typedef enum logic [PRES_W-1:0] {
        PRES_UNKNOWN = 2'd0,
        PRES_PRESENT = 2'd1,
        PRES_ABSENT  = 2'd2
    } presence_t;

    typedef enum logic [1:0] {
        REG_ENTER_SIGHTINGS = 2'd0,
        REG_ENTER_WINDOW    = 2'd1,
        REG_ABSENT_AFTER    = 2'd2,
        REG_RSSI_FLOOR      = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SMUL,
        ST_SADD,
        ST_GAP,
        ST_TRIM,
        ST_EVAL,
        ST_TICK,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [SIGHT_W-1:0]       need_hits;
        logic [WIN_W-1:0]         win_ms;
        logic [ABS_W-1:0]         silence_ms;
        logic signed [RSSI_W-1:0] rssi_floor;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic coverage;
        logic weak_inc;
        logic accept;
        logic smul;
        logic sadd;
        logic append;
        logic drop;
        logic eval;
        logic since_load;
        logic tick;
        logic out_load;
    } pd_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            covered;
        logic            below_floor;
        logic            rssi_on;
        logic            smooth_valid;
        logic            too_close;
        logic            front_old;
        logic            absent;
    } pd_status_t;

endpackage

`default_nettype wire

/* hw/rtl/presence_debouncer.sv */
// Presence debouncer top level: APB config registers, controller and datapath.
// Depends on pd_pkg, pd_ctrl and pd_dp.
//
// Usage:
//   Event words enter on the s_ channel (valid/ready): opcode 0 coverage change,
//   1 sighting, 2 time tick. Every accepted word yields exactly one result word
//   on the m_ channel: changed flag, presence (0 unknown, 1 present, 2 absent),
//   left_unknown, smoothed RSSI in Q7.8, and the saturating counters.
//   One word is processed at a time; s_ready is high only while the controller
//   idles. A coverage word, an unused opcode or a dropped sighting goes from
//   EXEC straight to DONE; a tick on a covered, not absent block passes
//   through TICK; a kept sighting runs the smoothing multiply and add (SMUL,
//   SADD) when RSSI smoothing applies, then the gap check and, unless the hit
//   is too close, the hit-window trim, which drops one stale hit per cycle,
//   and EVAL, before DONE.
//   The result sits in an output register: the next word is taken while it
//   waits. If the receiver stalls longer, the block holds the following
//   result in its final state until the output register frees up.
//   Reset (aresetn low, synchronous) returns presence to unknown, clears the
//   counters and smoothing, and loads the config defaults 2, 10000 ms,
//   60000 ms and -100 dBm. Write config over APB only while the block idles.
`timescale 1ns / 1ps
`default_nettype none

module presence_debouncer
    import pd_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // APB config port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_AW-1:0]        paddr,
    input  wire logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready,
    // event words in
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [OP_W-1:0]          s_opcode,
    input  wire logic [TIME_W-1:0]        s_now_ms,
    input  wire logic                     s_scanning,
    input  wire logic signed [RSSI_W-1:0] s_rssi,
    input  wire logic                     s_rssi_present,
    // result words out
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_changed,
    output logic [PRES_W-1:0]             m_presence,
    output logic                          m_left_unknown,
    output logic signed [SMOOTH_W-1:0]    m_rssi_smoothed,
    output logic                          m_rssi_smoothed_valid,
    output logic [CNT_W-1:0]              m_sighting_total,
    output logic [CNT_W-1:0]              m_weak_total,
    output logic [HITS_W-1:0]             m_hits_in_window
);

    cfg_t       cfg_reg, cfg_next;
    pd_cmd_t    cmd;
    pd_status_t sts;
    logic       cfg_wr;
    reg_idx_t   reg_idx;

    // registers sit at 4-byte strides; the low two address bits are ignored
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_ENTER_SIGHTINGS: cfg_next.need_hits  = pwdata[SIGHT_W-1:0];
                REG_ENTER_WINDOW:    cfg_next.win_ms     = pwdata[WIN_W-1:0];
                REG_ABSENT_AFTER:    cfg_next.silence_ms = pwdata[ABS_W-1:0];
                REG_RSSI_FLOOR:      cfg_next.rssi_floor = $signed(pwdata[RSSI_W-1:0]);
                default:             cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.need_hits  <= SIGHT_W'(2);
            cfg_reg.win_ms     <= WIN_W'(10000);
            cfg_reg.silence_ms <= ABS_W'(60000);
            cfg_reg.rssi_floor <= -8'sd100;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back; the floor comes back sign-extended
    always_comb begin
        case (reg_idx)
            REG_ENTER_SIGHTINGS: prdata = APB_DW'(cfg_reg.need_hits);
            REG_ENTER_WINDOW:    prdata = APB_DW'(cfg_reg.win_ms);
            REG_ABSENT_AFTER:    prdata = APB_DW'(cfg_reg.silence_ms);
            REG_RSSI_FLOOR:      prdata = APB_DW'(cfg_reg.rssi_floor);
            default:             prdata = '0;
        endcase
    end

    pd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pd_dp u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg_reg),
        .cmd                   (cmd),
        .sts                   (sts),
        .s_opcode              (s_opcode),
        .s_now_ms              (s_now_ms),
        .s_scanning            (s_scanning),
        .s_rssi                (s_rssi),
        .s_rssi_present        (s_rssi_present),
        .m_changed             (m_changed),
        .m_presence            (m_presence),
        .m_left_unknown        (m_left_unknown),
        .m_rssi_smoothed       (m_rssi_smoothed),
        .m_rssi_smoothed_valid (m_rssi_smoothed_valid),
        .m_sighting_total      (m_sighting_total),
        .m_weak_total          (m_weak_total),
        .m_hits_in_window      (m_hits_in_window)
    );

endmodule

`default_nettype wire

/* hw/rtl/pd_ctrl.sv */
// Controller for the presence debouncer: sequences one word through the datapath.
// Depends on pd_pkg; drives pd_dp through pd_cmd_t and reads pd_status_t back.
`timescale 1ns / 1ps
`default_nettype none

module pd_ctrl
    import pd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire pd_status_t sts,
    output pd_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (sts.opcode)
                    OP_COVERAGE: begin
                        cmd.coverage = 1'b1;
                    end
                    OP_SIGHTING: begin
                        if (sts.covered && sts.below_floor) begin
                            cmd.weak_inc = 1'b1;
                        end else if (sts.covered) begin
                            cmd.accept = 1'b1;
                            state_next = (sts.rssi_on && sts.smooth_valid) ? ST_SMUL : ST_GAP;
                        end
                    end
                    OP_TICK: begin
                        if (sts.covered && !sts.absent) begin
                            cmd.since_load = 1'b1;
                            state_next     = ST_TICK;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SMUL: begin
                cmd.smul   = 1'b1;
                state_next = ST_SADD;
            end
            ST_SADD: begin
                cmd.sadd   = 1'b1;
                state_next = ST_GAP;
            end
            ST_GAP: begin
                if (sts.too_close) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.append = 1'b1;
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                // drop one stale hit a cycle from the front
                if (sts.front_old) begin
                    cmd.drop = 1'b1;
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_DONE;
            end
            ST_TICK: begin
                cmd.tick   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/pd_dp.sv */
// Datapath for the presence debouncer: input latch, presence state, hit window,
// smoothing, counters and the result register. Depends on pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_dp
    import pd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire pd_cmd_t              cmd,
    output pd_status_t                sts,
    input  wire logic [OP_W-1:0]      s_opcode,
    input  wire logic [TIME_W-1:0]    s_now_ms,
    input  wire logic                 s_scanning,
    input  wire logic signed [RSSI_W-1:0] s_rssi,
    input  wire logic                 s_rssi_present,
    output logic                      m_changed,
    output logic [PRES_W-1:0]         m_presence,
    output logic                      m_left_unknown,
    output logic signed [SMOOTH_W-1:0] m_rssi_smoothed,
    output logic                      m_rssi_smoothed_valid,
    output logic [CNT_W-1:0]          m_sighting_total,
    output logic [CNT_W-1:0]          m_weak_total,
    output logic [HITS_W-1:0]         m_hits_in_window
);

    // Latched input word
    logic [OP_W-1:0]          op_reg, op_next;
    logic [TIME_W-1:0]        now_reg, now_next;
    logic                     scan_reg, scan_next;
    logic signed [RSSI_W-1:0] rssi_reg, rssi_next;
    logic                     rssi_on_reg, rssi_on_next;

    // Block state
    presence_t               presence_reg, presence_next;
    logic                    from_unk_reg, from_unk_next;
    logic                    changed_reg, changed_next;
    logic                    covered_reg, covered_next;
    logic [TIME_W-1:0]       cov_since_reg, cov_since_next;
    logic [TIME_W-1:0]       last_seen_reg, last_seen_next;
    logic [TIME_W-1:0]       last_hit_reg, last_hit_next;
    logic [TIME_W-1:0]       since_reg, since_next;
    logic [TIME_W-1:0]       hits_reg [MAX_HITS];
    logic [TIME_W-1:0]       hits_next [MAX_HITS];
    logic [HIT_CNT_W-1:0]    hit_cnt_reg, hit_cnt_next;
    logic signed [SMOOTH_W-1:0] smooth_reg, smooth_next;
    logic                    smooth_valid_reg, smooth_valid_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]        acc_cnt_reg, acc_cnt_next;
    logic [CNT_W-1:0]        weak_cnt_reg, weak_cnt_next;

    // Result word
    logic                      m_changed_reg, m_left_unknown_reg, m_smooth_valid_reg;
    logic [PRES_W-1:0]         m_presence_reg;
    logic signed [SMOOTH_W-1:0] m_smooth_reg;
    logic [CNT_W-1:0]          m_acc_reg, m_weak_reg;
    logic [HITS_W-1:0]         m_hits_reg;

    logic                      become_en;
    presence_t                 become_to;
    logic signed [SMOOTH_W-1:0] r_q8;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [SUM_W-1:0]   smooth_sum;
    logic [TIME_W-1:0]         quiet_ms;

    assign r_q8       = {rssi_reg, 8'h00};
    assign rounded    = prod_reg + ROUND_K;
    assign smooth_sum = SUM_W'(smooth_reg) + SUM_W'($signed(rounded[PROD_W-1:16]));
    assign quiet_ms   = now_reg - since_reg;

    always_comb begin
        sts.opcode       = op_reg;
        sts.covered      = covered_reg;
        sts.below_floor  = rssi_on_reg && (rssi_reg < cfg.rssi_floor);
        sts.rssi_on      = rssi_on_reg;
        sts.smooth_valid = smooth_valid_reg;
        sts.too_close    = (hit_cnt_reg != '0)
                           && ((now_reg - last_hit_reg) < TIME_W'(LEAST_GAP_MS));
        sts.front_old    = (hit_cnt_reg != '0)
                           && ((now_reg - hits_reg[0]) > TIME_W'(cfg.win_ms));
        sts.absent       = (presence_reg == PRES_ABSENT);
    end

    always_comb begin
        op_next           = op_reg;
        now_next          = now_reg;
        scan_next         = scan_reg;
        rssi_next         = rssi_reg;
        rssi_on_next      = rssi_on_reg;
        presence_next     = presence_reg;
        from_unk_next     = from_unk_reg;
        changed_next      = changed_reg;
        covered_next      = covered_reg;
        cov_since_next    = cov_since_reg;
        last_seen_next    = last_seen_reg;
        last_hit_next     = last_hit_reg;
        since_next        = since_reg;
        hits_next         = hits_reg;
        hit_cnt_next      = hit_cnt_reg;
        smooth_next       = smooth_reg;
        smooth_valid_next = smooth_valid_reg;
        diff_next         = diff_reg;
        prod_next         = prod_reg;
        acc_cnt_next      = acc_cnt_reg;
        weak_cnt_next     = weak_cnt_reg;
        become_en         = 1'b0;
        become_to         = presence_reg;

        if (cmd.load_in) begin
            op_next       = s_opcode;
            now_next      = s_now_ms;
            scan_next     = s_scanning;
            rssi_next     = s_rssi;
            rssi_on_next  = s_rssi_present;
            changed_next  = 1'b0;
        end

        if (cmd.coverage) begin
            if (scan_reg) begin
                if (!covered_reg) begin
                    covered_next   = 1'b1;
                    cov_since_next = now_reg;
                end
            end else begin
                covered_next   = 1'b0;
                cov_since_next = '0;
                hit_cnt_next   = '0;
                become_en      = 1'b1;
                become_to      = PRES_UNKNOWN;
            end
        end

        if (cmd.weak_inc && (weak_cnt_reg != '1)) begin
            weak_cnt_next = weak_cnt_reg + 1'b1;
        end

        if (cmd.accept) begin
            if (acc_cnt_reg != '1) begin
                acc_cnt_next = acc_cnt_reg + 1'b1;
            end
            last_seen_next = now_reg;
            if (rssi_on_reg) begin
                if (!smooth_valid_reg) begin
                    smooth_next       = r_q8;
                    smooth_valid_next = 1'b1;
                end else begin
                    diff_next = DIFF_W'(r_q8) - DIFF_W'(smooth_reg);
                end
            end
        end

        if (cmd.smul) begin
            prod_next = PROD_W'(diff_reg) * PROD_W'(SMOOTH_K);
        end

        if (cmd.sadd) begin
            if (smooth_sum > SMOOTH_HI) begin
                smooth_next = SMOOTH_HI[SMOOTH_W-1:0];
            end else if (smooth_sum < SMOOTH_LO) begin
                smooth_next = SMOOTH_LO[SMOOTH_W-1:0];
            end else begin
                smooth_next = smooth_sum[SMOOTH_W-1:0];
            end
        end

        if (cmd.append) begin
            last_hit_next = now_reg;
            if (hit_cnt_reg == HIT_CNT_W'(MAX_HITS)) begin
                // full: shift out the oldest hit, newest goes to the top
                for (int i = 0; i < MAX_HITS - 1; i++) begin
                    hits_next[i] = hits_reg[i + 1];
                end
                hits_next[MAX_HITS - 1] = now_reg;
            end else begin
                hits_next[hit_cnt_reg[HIT_IDX_W-1:0]] = now_reg;
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end

        if (cmd.drop) begin
            for (int i = 0; i < MAX_HITS - 1; i++) begin
                hits_next[i] = hits_reg[i + 1];
            end
            hit_cnt_next = hit_cnt_reg - 1'b1;
        end

        if (cmd.eval && (presence_reg != PRES_PRESENT)
            && (8'(hit_cnt_reg) >= 8'(cfg.need_hits))) begin
            become_en = 1'b1;
            become_to = PRES_PRESENT;
        end

        if (cmd.since_load) begin
            since_next = (last_seen_reg > cov_since_reg) ? last_seen_reg : cov_since_reg;
        end

        if (cmd.tick && (now_reg >= since_reg)
            && (quiet_ms >= TIME_W'(cfg.silence_ms))) begin
            hit_cnt_next = '0;
            become_en    = 1'b1;
            become_to    = PRES_ABSENT;
        end

        if (become_en && (become_to != presence_reg)) begin
            from_unk_next = (presence_reg == PRES_UNKNOWN);
            presence_next = become_to;
            changed_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presence_reg     <= PRES_UNKNOWN;
            from_unk_reg     <= 1'b0;
            changed_reg      <= 1'b0;
            covered_reg      <= 1'b0;
            cov_since_reg    <= '0;
            last_seen_reg    <= '0;
            hit_cnt_reg      <= '0;
            smooth_reg       <= '0;
            smooth_valid_reg <= 1'b0;
            acc_cnt_reg      <= '0;
            weak_cnt_reg     <= '0;
        end else begin
            presence_reg     <= presence_next;
            from_unk_reg     <= from_unk_next;
            changed_reg      <= changed_next;
            covered_reg      <= covered_next;
            cov_since_reg    <= cov_since_next;
            last_seen_reg    <= last_seen_next;
            hit_cnt_reg      <= hit_cnt_next;
            smooth_reg       <= smooth_next;
            smooth_valid_reg <= smooth_valid_next;
            acc_cnt_reg      <= acc_cnt_next;
            weak_cnt_reg     <= weak_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        scan_reg     <= scan_next;
        rssi_reg     <= rssi_next;
        rssi_on_reg  <= rssi_on_next;
        last_hit_reg <= last_hit_next;
        since_reg    <= since_next;
        hits_reg     <= hits_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        if (cmd.out_load) begin
            m_changed_reg      <= changed_reg;
            m_presence_reg     <= presence_reg;
            m_left_unknown_reg <= from_unk_reg;
            m_smooth_reg       <= smooth_reg;
            m_smooth_valid_reg <= smooth_valid_reg;
            m_acc_reg          <= acc_cnt_reg;
            m_weak_reg         <= weak_cnt_reg;
            m_hits_reg         <= HITS_W'(hit_cnt_reg);
        end
    end

    assign m_changed             = m_changed_reg;
    assign m_presence            = m_presence_reg;
    assign m_left_unknown        = m_left_unknown_reg;
    assign m_rssi_smoothed       = m_smooth_reg;
    assign m_rssi_smoothed_valid = m_smooth_valid_reg;
    assign m_sighting_total      = m_acc_reg;
    assign m_weak_total          = m_weak_reg;
    assign m_hits_in_window      = m_hits_reg;

endmodule

`default_nettype wire

/* hw/rtl/pd_checker.sv */
// Port-level checks for the presence debouncer, bound to the top level.
// Depends on pd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pd_checker
    import pd_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_changed,
    input wire logic [PRES_W-1:0] m_presence,
    input wire logic [HITS_W-1:0] m_hits_in_window,
    input wire logic [CNT_W-1:0]  m_sighting_total
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_presence) && $stable(m_changed))
        else $error("result word changed while stalled");

    // the window never holds more than its depth
    a_hits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hits_in_window <= HITS_W'(MAX_HITS)))
        else $error("hit count beyond window depth");

    // a change into unknown or absent always empties the window
    a_leave_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_changed && (m_presence != PRES_PRESENT) |-> (m_hits_in_window == '0))
        else $error("hits kept across a change out of present");

    // present is reached only through an accepted sighting
    a_present_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_presence == PRES_PRESENT) |-> (m_sighting_total != '0))
        else $error("present without any accepted sighting");

endmodule

bind presence_debouncer pd_checker u_pd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_changed        (m_changed),
    .m_presence       (m_presence),
    .m_hits_in_window (m_hits_in_window),
    .m_sighting_total (m_sighting_total)
);

`default_nettype wire
